/* rtl/kpc_pkg.sv */
// Package for the key press classifier: sizes, register codes, reset values
// and the shared payload and configuration types. No dependencies.
package kpc_pkg;

   localparam int KEYS       = 4;
   localparam int FIRST_PIN  = 5;
   localparam int PORT_W     = 16;
   localparam int MASK_W     = 4;
   localparam int TICK_W     = 6;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [TICK_W-1:0]  TICK_MAX          = '1;
   localparam logic [TICK_W-1:0]  LONG_TICKS_RESET  = TICK_W'(50);
   localparam logic [TICK_W-1:0]  RELOAD_RESET      = TICK_W'(45);
   localparam logic [COUNT_W-1:0] PER_STEP_RESET    = COUNT_W'(10);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_PRESS_TICKS = 2'd0,
      CSR_REPEAT_RELOAD    = 2'd1,
      CSR_REPEATS_PER_STEP = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TICK_W-1:0]  long_press_ticks;
      logic [TICK_W-1:0]  repeat_reload;
      logic [COUNT_W-1:0] repeats_per_step;
   } cfg_type;

   typedef struct packed {
      logic [MASK_W-1:0]  pressed_mask;
      logic [MASK_W-1:0]  trigger_mask;
      logic [MASK_W-1:0]  short_mask;
      logic [MASK_W-1:0]  long_mask;
      logic [MASK_W-1:0]  repeat_mask;
      logic [COUNT_W-1:0] hold_steps;
   } rsp_type;

   // Per-key flags after one tick's update.
   typedef struct packed {
      logic short_flag;
      logic long_flag;
      logic repeat_flag;
   } lane_flags_type;

   // Widen or trim a per-key mask to the result field width.
   function automatic logic [MASK_W-1:0] fit_mask(input logic [KEYS-1:0] m);
      logic [KEYS+MASK_W-1:0] wide;
      wide = {{MASK_W{1'b0}}, m};
      return wide[MASK_W-1:0];
   endfunction

   // Active-low port pins to an active-high key vector.
   function automatic logic [KEYS-1:0] pick_keys(input logic [PORT_W-1:0] port);
      logic [PORT_W-1:0] inv;
      inv = (~port) >> FIRST_PIN;
      return inv[KEYS-1:0];
   endfunction

endpackage

/* rtl/kpc_req_if.sv */
// Scan tick channel: valid/ready plus the raw port sample and key query.
// Depends on kpc_pkg for field widths.
interface kpc_req_if;
   logic                            valid;
   logic                            ready;
   logic [kpc_pkg::PORT_W-1:0]      port_word;
   logic [kpc_pkg::MASK_W-1:0]      query_key_mask;

   modport source (output valid, output port_word, output query_key_mask, input ready);
   modport sink   (input valid, input port_word, input query_key_mask, output ready);
endinterface

/* rtl/kpc_rsp_if.sv */
// Result channel: valid/ready plus the classified key masks and hold steps.
// Depends on kpc_pkg for field widths.
interface kpc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kpc_pkg::MASK_W-1:0]   pressed_mask;
   logic [kpc_pkg::MASK_W-1:0]   trigger_mask;
   logic [kpc_pkg::MASK_W-1:0]   short_mask;
   logic [kpc_pkg::MASK_W-1:0]   long_mask;
   logic [kpc_pkg::MASK_W-1:0]   repeat_mask;
   logic [kpc_pkg::COUNT_W-1:0]  hold_steps;

   modport source (output valid, output pressed_mask, output trigger_mask,
                   output short_mask, output long_mask, output repeat_mask,
                   output hold_steps, input ready);
   modport sink   (input valid, input pressed_mask, input trigger_mask,
                   input short_mask, input long_mask, input repeat_mask,
                   input hold_steps, output ready);
endinterface

/* rtl/kpc_csr_if.sv */
// Register write channel: valid/ready plus register index and write data.
// Depends on kpc_pkg for field widths.
interface kpc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [kpc_pkg::CSR_IDX_W-1:0]    index;
   logic [kpc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/kpc_lane.sv */
// One key's hold counter, repeat counter, step counter and press flags.
// Depends on kpc_pkg; state advances on each accepted scan tick.
module kpc_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          pressed,
   input  kpc_pkg::cfg_type              cfg,
   output kpc_pkg::lane_flags_type       flags_in,
   output logic [kpc_pkg::COUNT_W-1:0]   steps_in
);

   logic [kpc_pkg::TICK_W-1:0]   held_ff, held_in;
   logic [kpc_pkg::COUNT_W-1:0]  events_ff, events_in;
   logic [kpc_pkg::COUNT_W-1:0]  steps_ff;
   kpc_pkg::lane_flags_type      flags_ff;
   logic [kpc_pkg::TICK_W-1:0]   count;
   logic [kpc_pkg::COUNT_W-1:0]  events_inc;

   always_comb begin
      held_in    = '0;
      events_in  = events_ff;
      steps_in   = steps_ff;
      flags_in   = flags_ff;
      count      = held_ff;
      events_inc = events_ff + 1'b1;
      if (pressed) begin
         // saturate rather than wrap
         if (held_ff != kpc_pkg::TICK_MAX) begin
            count = held_ff + 1'b1;
         end
         if (count < cfg.long_press_ticks) begin
            flags_in.repeat_flag = 1'b0;
         end
         if (count == cfg.long_press_ticks) begin
            flags_in.long_flag   = 1'b1;
            flags_in.repeat_flag = 1'b1;
            count                = cfg.repeat_reload;
            events_in            = events_inc;
            if (events_inc >= cfg.repeats_per_step) begin
               steps_in  = steps_ff + 1'b1;
               events_in = '0;
            end
         end
         held_in = count;
      end else if (held_ff != '0 && held_ff < cfg.repeat_reload) begin
         flags_in.short_flag = 1'b1;
      end else begin
         flags_in  = '0;
         events_in = '0;
         steps_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         events_ff <= '0;
         steps_ff  <= '0;
         flags_ff  <= '0;
      end else if (advance) begin
         held_ff   <= held_in;
         events_ff <= events_in;
         steps_ff  <= steps_in;
         flags_ff  <= flags_in;
      end
   end

endmodule

/* rtl/kpc_skid.sv */
// Result register with a skid entry so a tick can be taken while a result waits.
// Depends on kpc_pkg for the result type.
module kpc_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  kpc_pkg::rsp_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output kpc_pkg::rsp_type  out_data
);

   logic              out_vld_ff, out_vld_in;
   logic              skid_vld_ff, skid_vld_in;
   kpc_pkg::rsp_type  out_ff, out_in;
   kpc_pkg::rsp_type  skid_ff, skid_in;
   logic              accept;
   logic              slot_free;

   assign in_ready  = !skid_vld_ff;
   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;
   assign accept    = in_valid && !skid_vld_ff;
   assign slot_free = !out_vld_ff || out_ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (slot_free) begin
         if (skid_vld_ff) begin
            // drain the skid entry first
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = in_data;
            out_vld_in = accept;
         end
      end else if (accept) begin
         skid_in     = in_data;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

/* rtl/key_press_classifier.sv */
// Key press classifier top level: debounce, per-key lanes, query select, output buffer.
// Depends on kpc_pkg, kpc_req_if, kpc_rsp_if, kpc_csr_if, kpc_lane and kpc_skid.

// Takes one scan tick per clock cycle while req_ch.ready is high and returns one result beat
// per tick, in order. Each tick is debounced against the previous sample and all key lanes
// update in the same cycle; the result is registered in the output stage, or in the skid
// entry while the output stage waits. A two-entry output buffer keeps the tick channel ready
// while one result waits, so req_ch.ready drops only when two results are pending. Register
// writes are taken at any time and should be made while no tick is in flight.
module key_press_classifier (
   input  logic        clock,
   input  logic        reset,
   kpc_req_if.sink     req_ch,
   kpc_rsp_if.source   rsp_ch,
   kpc_csr_if.sink     csr_ch
);

   kpc_pkg::cfg_type               cfg_ff;
   logic [kpc_pkg::KEYS-1:0]       last_sample_ff;
   logic [kpc_pkg::KEYS-1:0]       debounced_ff;
   logic [kpc_pkg::KEYS-1:0]       now_keys;
   logic [kpc_pkg::KEYS-1:0]       deb_keys;
   logic [kpc_pkg::KEYS-1:0]       trig_keys;
   logic [kpc_pkg::KEYS-1:0]       short_keys;
   logic [kpc_pkg::KEYS-1:0]       long_keys;
   logic [kpc_pkg::KEYS-1:0]       repeat_keys;
   logic [kpc_pkg::COUNT_W-1:0]    lane_steps [kpc_pkg::KEYS];
   logic [kpc_pkg::COUNT_W-1:0]    step_pad [kpc_pkg::MASK_W];
   logic [kpc_pkg::COUNT_W-1:0]    query_steps;
   logic                           tick_ready;
   logic                           accept;
   kpc_pkg::rsp_type               rsp_data;
   kpc_pkg::rsp_type               rsp_out;

   assign req_ch.ready = tick_ready;
   assign accept       = req_ch.valid && tick_ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks <= kpc_pkg::LONG_TICKS_RESET;
         cfg_ff.repeat_reload    <= kpc_pkg::RELOAD_RESET;
         cfg_ff.repeats_per_step <= kpc_pkg::PER_STEP_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            kpc_pkg::CSR_LONG_PRESS_TICKS:
               cfg_ff.long_press_ticks <= csr_ch.data[kpc_pkg::TICK_W-1:0];
            kpc_pkg::CSR_REPEAT_RELOAD:
               cfg_ff.repeat_reload    <= csr_ch.data[kpc_pkg::TICK_W-1:0];
            kpc_pkg::CSR_REPEATS_PER_STEP:
               cfg_ff.repeats_per_step <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // a key counts as down only if low in this sample and the last one
   assign now_keys  = kpc_pkg::pick_keys(req_ch.port_word);
   assign deb_keys  = now_keys & last_sample_ff;
   assign trig_keys = deb_keys & ~debounced_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
         debounced_ff   <= '0;
      end else if (accept) begin
         last_sample_ff <= now_keys;
         debounced_ff   <= deb_keys;
      end
   end

   for (genvar k = 0; k < kpc_pkg::KEYS; k++) begin : g_lane
      kpc_pkg::lane_flags_type flags;

      kpc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .advance  (accept),
         .pressed  (deb_keys[k]),
         .cfg      (cfg_ff),
         .flags_in (flags),
         .steps_in (lane_steps[k])
      );

      assign short_keys[k]  = flags.short_flag;
      assign long_keys[k]   = flags.long_flag;
      assign repeat_keys[k] = flags.repeat_flag;
   end

   for (genvar j = 0; j < kpc_pkg::MASK_W; j++) begin : g_pad
      if (j < kpc_pkg::KEYS) begin : g_key
         assign step_pad[j] = lane_steps[j];
      end else begin : g_none
         assign step_pad[j] = '0;
      end
   end

   // lowest set query bit wins
   always_comb begin
      query_steps = '0;
      for (int j = kpc_pkg::MASK_W - 1; j >= 0; j--) begin
         if (req_ch.query_key_mask[j]) begin
            query_steps = step_pad[j];
         end
      end
   end

   always_comb begin
      rsp_data.pressed_mask = kpc_pkg::fit_mask(deb_keys);
      rsp_data.trigger_mask = kpc_pkg::fit_mask(trig_keys);
      rsp_data.short_mask   = kpc_pkg::fit_mask(short_keys);
      rsp_data.long_mask    = kpc_pkg::fit_mask(long_keys);
      rsp_data.repeat_mask  = kpc_pkg::fit_mask(repeat_keys);
      rsp_data.hold_steps   = query_steps;
   end

   kpc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (tick_ready),
      .in_data   (rsp_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_out)
   );

   assign rsp_ch.pressed_mask = rsp_out.pressed_mask;
   assign rsp_ch.trigger_mask = rsp_out.trigger_mask;
   assign rsp_ch.short_mask   = rsp_out.short_mask;
   assign rsp_ch.long_mask    = rsp_out.long_mask;
   assign rsp_ch.repeat_mask  = rsp_out.repeat_mask;
   assign rsp_ch.hold_steps   = rsp_out.hold_steps;

endmodule
